### rtl/arp_pkg.sv
// Shared types, constants and codes for the ARP cache resolver.
package arp_pkg;

   // Defaults for the top-level parameters
   localparam int ENTRIES_DEF     = 16;
   localparam int HANDLE_BITS_DEF = 8;

   // Field widths
   localparam int MAC_W = 48;
   localparam int IP_W  = 32;
   localparam int HND_W = 8;
   localparam int ET_W  = 16;
   localparam int CSR_W = 48;

   // Frame checks and opcodes
   localparam logic [15:0] HW_ETHERNET      = 16'h0001;
   localparam logic [15:0] PROTO_IPV4       = 16'h0800;
   localparam logic [15:0] FRAME_OP_REQUEST = 16'h0001;
   localparam logic [1:0]  SENT_OP_NONE     = 2'd0;
   localparam logic [1:0]  SENT_OP_REQUEST  = 2'd1;
   localparam logic [1:0]  SENT_OP_REPLY    = 2'd2;
   localparam logic [MAC_W-1:0] MAC_BROADCAST = {MAC_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_FRAME   = 2'd0,
      CMD_RESOLVE = 2'd1,
      CMD_LOOKUP  = 2'd2
   } command_type;

   typedef enum logic {
      CSR_OWN_IP  = 1'b0,
      CSR_OWN_MAC = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_LOOKUP   = 3'd0,
      KIND_SEND_ARP = 3'd1,
      KIND_DISCARD  = 3'd2,
      KIND_FORWARD  = 3'd3,
      KIND_FULL     = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_OUT_A,
      ST_OUT_B
   } state_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [15:0]      hw_type;
      logic [15:0]      proto_type;
      logic [15:0]      frame_opcode;
      logic             frame_complete;
      logic [MAC_W-1:0] sender_mac;
      logic [IP_W-1:0]  sender_ip;
      logic [IP_W-1:0]  target_ip;
      logic [HND_W-1:0] packet_handle;
      logic [ET_W-1:0]  packet_ethertype;
   } req_type;

   typedef struct packed {
      logic [2:0]       result_kind;
      logic [1:0]       sent_opcode;
      logic [MAC_W-1:0] dest_mac;
      logic [MAC_W-1:0] frame_target_mac;
      logic [IP_W-1:0]  addr_ip;
      logic             found;
      logic [HND_W-1:0] handle_out;
      logic [ET_W-1:0]  ethertype_out;
      logic             last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic apply;
      logic sel_b;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic       scan_done;
      logic [1:0] res_cnt;
   } dp_stat_type;

endpackage

### rtl/arp_chan_if.sv
// Valid/ready channel interface carrying one payload item.
interface arp_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/arp_dpath.sv
// Datapath: config registers, cache memories, scan pipeline and result builder.
module arp_dpath #(
   parameter int ENTRIES     = arp_pkg::ENTRIES_DEF,
   parameter int HANDLE_BITS = arp_pkg::HANDLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  arp_pkg::req_type           req_data,
   input  arp_pkg::ctrl_cmd_type      ctrl_cmd,
   output arp_pkg::dp_stat_type       dp_stat,
   output arp_pkg::rsp_type           rsp_data,
   input  logic                       csr_wr_en,
   input  logic                       csr_index,
   input  logic [arp_pkg::CSR_W-1:0]  csr_wr_data
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
   localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);

   // Configuration registers
   logic [arp_pkg::IP_W-1:0]  own_ip_ff;
   logic [arp_pkg::MAC_W-1:0] own_mac_ff;

   // Captured request
   arp_pkg::req_type req_ff;

   // Cache storage
   logic [arp_pkg::IP_W-1:0]  ip_mem  [ENTRIES];
   logic [arp_pkg::MAC_W-1:0] mac_mem [ENTRIES];
   logic [HANDLE_BITS-1:0]    hnd_mem [ENTRIES];
   logic [arp_pkg::ET_W-1:0]  et_mem  [ENTRIES];
   logic [ENTRIES-1:0]        valid_ff;
   logic [ENTRIES-1:0]        parked_ff;

   // Scan pipeline
   logic [CW-1:0]             rd_cnt_ff, rd_cnt_in;
   logic                      rd_issue;
   logic [IW-1:0]             rd_addr;
   logic                      cmp_vld_ff;
   logic [IW-1:0]             cmp_idx_ff;
   logic [arp_pkg::IP_W-1:0]  ip_rd_ff;
   logic [arp_pkg::MAC_W-1:0] mac_rd_ff;
   logic [HANDLE_BITS-1:0]    hnd_rd_ff;
   logic [arp_pkg::ET_W-1:0]  et_rd_ff;
   logic [arp_pkg::IP_W-1:0]  key;
   logic                      ent_hit, ent_free;
   logic                      scan_done;

   // Scan results
   logic                      hit_ff, free_ff;
   logic [IW-1:0]             hit_idx_ff, free_idx_ff;
   logic [arp_pkg::MAC_W-1:0] hit_mac_ff;
   logic [HANDLE_BITS-1:0]    hit_hnd_ff;
   logic [arp_pkg::ET_W-1:0]  hit_et_ff;

   // Apply step
   logic                      frame_ok, tip_own, hit_parked;
   logic [IW-1:0]             wr_idx;
   logic                      wr_ip_en, wr_mac_en, wr_park_en;
   logic [arp_pkg::IP_W-1:0]  wr_ip;
   logic [arp_pkg::MAC_W-1:0] wr_mac;
   logic                      set_valid, set_park, clr_park;
   logic [HANDLE_BITS-1:0]    hnd_req;
   logic                      v0, v1;
   logic [1:0]                res_cnt;
   arp_pkg::rsp_type          c0, c1, first, second;
   arp_pkg::rsp_type          res_a_ff, res_b_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff  <= '0;
         own_mac_ff <= '0;
      end else if (csr_wr_en) begin
         case (arp_pkg::csr_index_type'(csr_index))
            arp_pkg::CSR_OWN_IP:  own_ip_ff  <= csr_wr_data[arp_pkg::IP_W-1:0];
            arp_pkg::CSR_OWN_MAC: own_mac_ff <= csr_wr_data[arp_pkg::MAC_W-1:0];
            default: ;
         endcase
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         req_ff <= req_data;
      end
   end

   // Scan address counter
   always_comb begin
      rd_issue  = ctrl_cmd.scan && (rd_cnt_ff != CNT_END);
      rd_addr   = rd_cnt_ff[IW-1:0];
      rd_cnt_in = rd_cnt_ff;
      if (ctrl_cmd.load) begin
         rd_cnt_in = '0;
      end else if (rd_issue) begin
         rd_cnt_in = rd_cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff  <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         rd_cnt_ff  <= rd_cnt_in;
         cmp_vld_ff <= rd_issue;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= rd_addr;
   end

   // Registered memory reads at the scan address
   always_ff @(posedge clock) begin
      ip_rd_ff  <= ip_mem[rd_addr];
      mac_rd_ff <= mac_mem[rd_addr];
      hnd_rd_ff <= hnd_mem[rd_addr];
      et_rd_ff  <= et_mem[rd_addr];
   end

   // Compare stage: first matching entry and first free entry
   always_comb begin
      key = (req_ff.command == arp_pkg::CMD_FRAME) ? req_ff.sender_ip : req_ff.target_ip;
      ent_hit   = cmp_vld_ff && valid_ff[cmp_idx_ff] && (ip_rd_ff == key) && (key != '0);
      ent_free  = cmp_vld_ff && !valid_ff[cmp_idx_ff];
      scan_done = cmp_vld_ff && (cmp_idx_ff == LAST_IDX);
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl_cmd.load) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         if (ent_hit) hit_ff <= 1'b1;
         if (ent_free) free_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_hit && !hit_ff) begin
         hit_idx_ff <= cmp_idx_ff;
         hit_mac_ff <= mac_rd_ff;
         hit_hnd_ff <= hnd_rd_ff;
         hit_et_ff  <= et_rd_ff;
      end
      if (ent_free && !free_ff) begin
         free_idx_ff <= cmp_idx_ff;
      end
   end

   // Apply: decide writes and up to two results
   always_comb begin
      frame_ok   = (req_ff.hw_type == arp_pkg::HW_ETHERNET) &&
                   (req_ff.proto_type == arp_pkg::PROTO_IPV4) && req_ff.frame_complete;
      tip_own    = (req_ff.target_ip == own_ip_ff);
      hit_parked = parked_ff[hit_idx_ff];
      hnd_req    = HANDLE_BITS'(req_ff.packet_handle);
      wr_idx     = hit_ff ? hit_idx_ff : free_idx_ff;
      wr_ip_en   = 1'b0;
      wr_mac_en  = 1'b0;
      wr_park_en = 1'b0;
      wr_ip      = req_ff.target_ip;
      wr_mac     = '0;
      set_valid  = 1'b0;
      set_park   = 1'b0;
      clr_park   = 1'b0;
      v0         = 1'b0;
      v1         = 1'b0;
      c0         = '0;
      c1         = '0;
      case (req_ff.command)
         arp_pkg::CMD_FRAME: begin
            if (frame_ok) begin
               // refresh a known sender and release its parked packet
               if (hit_ff) begin
                  wr_mac_en = 1'b1;
                  wr_mac    = req_ff.sender_mac;
                  if (hit_parked) begin
                     v0               = 1'b1;
                     c0.result_kind   = arp_pkg::KIND_FORWARD;
                     c0.dest_mac      = req_ff.sender_mac;
                     c0.addr_ip       = req_ff.sender_ip;
                     c0.handle_out    = arp_pkg::HND_W'(hit_hnd_ff);
                     c0.ethertype_out = hit_et_ff;
                     clr_park         = 1'b1;
                  end
               end
               if (tip_own) begin
                  // learn the sender when the frame is for us
                  if (!hit_ff && (req_ff.sender_ip != '0) && free_ff) begin
                     wr_ip_en  = 1'b1;
                     wr_mac_en = 1'b1;
                     wr_ip     = req_ff.sender_ip;
                     wr_mac    = req_ff.sender_mac;
                     set_valid = 1'b1;
                     clr_park  = 1'b1;
                  end
                  if (req_ff.frame_opcode == arp_pkg::FRAME_OP_REQUEST) begin
                     v1                  = 1'b1;
                     c1.result_kind      = arp_pkg::KIND_SEND_ARP;
                     c1.sent_opcode      = arp_pkg::SENT_OP_REPLY;
                     c1.dest_mac         = req_ff.sender_mac;
                     c1.frame_target_mac = req_ff.sender_mac;
                     c1.addr_ip          = req_ff.sender_ip;
                  end
               end
            end
         end
         arp_pkg::CMD_RESOLVE: begin
            if (req_ff.target_ip == '0) begin
               v0             = 1'b1;
               c0.result_kind = arp_pkg::KIND_DISCARD;
               c0.handle_out  = arp_pkg::HND_W'(hnd_req);
            end else if (!hit_ff && !free_ff) begin
               v0             = 1'b1;
               c0.result_kind = arp_pkg::KIND_FULL;
               c0.handle_out  = arp_pkg::HND_W'(hnd_req);
            end else begin
               // an older parked packet is dropped in favor of the new one
               if (hit_ff && hit_parked) begin
                  v0             = 1'b1;
                  c0.result_kind = arp_pkg::KIND_DISCARD;
                  c0.handle_out  = arp_pkg::HND_W'(hit_hnd_ff);
               end
               if (!hit_ff) begin
                  wr_ip_en  = 1'b1;
                  wr_mac_en = 1'b1;
                  set_valid = 1'b1;
               end
               set_park       = 1'b1;
               wr_park_en     = 1'b1;
               v1             = 1'b1;
               c1.result_kind = arp_pkg::KIND_SEND_ARP;
               c1.sent_opcode = arp_pkg::SENT_OP_REQUEST;
               c1.dest_mac    = arp_pkg::MAC_BROADCAST;
               c1.addr_ip     = req_ff.target_ip;
            end
         end
         arp_pkg::CMD_LOOKUP: begin
            v0             = 1'b1;
            c0.result_kind = arp_pkg::KIND_LOOKUP;
            c0.dest_mac    = hit_ff ? hit_mac_ff : '0;
            c0.found       = hit_ff;
         end
         default: ;
      endcase
      first       = v0 ? c0 : c1;
      first.last  = !(v0 && v1);
      second      = c1;
      second.last = 1'b1;
      res_cnt     = {1'b0, v0} + {1'b0, v1};
   end

   // Entry flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         parked_ff <= '0;
      end else if (ctrl_cmd.apply) begin
         if (set_valid) valid_ff[wr_idx] <= 1'b1;
         if (clr_park) parked_ff[wr_idx] <= 1'b0;
         if (set_park) parked_ff[wr_idx] <= 1'b1;
      end
   end

   // Memory writes
   always_ff @(posedge clock) begin
      if (ctrl_cmd.apply) begin
         if (wr_ip_en) ip_mem[wr_idx] <= wr_ip;
         if (wr_mac_en) mac_mem[wr_idx] <= wr_mac;
         if (wr_park_en) begin
            hnd_mem[wr_idx] <= hnd_req;
            et_mem[wr_idx]  <= req_ff.packet_ethertype;
         end
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (ctrl_cmd.apply) begin
         res_a_ff <= first;
         res_b_ff <= second;
      end
   end

   // Status back to the controller
   assign dp_stat = '{scan_done: scan_done, res_cnt: res_cnt};

   assign rsp_data = ctrl_cmd.sel_b ? res_b_ff : res_a_ff;

endmodule

### rtl/arp_ctrl.sv
// Controller: sequences capture, scan, apply and result delivery.
module arp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  arp_pkg::dp_stat_type  dp_stat,
   output arp_pkg::ctrl_cmd_type ctrl_cmd,
   output arp_pkg::state_type    state
);

   arp_pkg::state_type state_ff, state_in;
   logic               two_ff, two_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arp_pkg::ST_IDLE;
         two_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         two_ff   <= two_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      two_in    = two_ff;
      ctrl_cmd  = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         arp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl_cmd.load = 1'b1;
               state_in      = arp_pkg::ST_SCAN;
            end
         end
         arp_pkg::ST_SCAN: begin
            ctrl_cmd.scan = 1'b1;
            if (dp_stat.scan_done) state_in = arp_pkg::ST_APPLY;
         end
         arp_pkg::ST_APPLY: begin
            ctrl_cmd.apply = 1'b1;
            two_in         = (dp_stat.res_cnt == 2'd2);
            state_in       = (dp_stat.res_cnt == 2'd0) ? arp_pkg::ST_IDLE : arp_pkg::ST_OUT_A;
         end
         arp_pkg::ST_OUT_A: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = two_ff ? arp_pkg::ST_OUT_B : arp_pkg::ST_IDLE;
         end
         arp_pkg::ST_OUT_B: begin
            rsp_valid      = 1'b1;
            ctrl_cmd.sel_b = 1'b1;
            if (rsp_ready) state_in = arp_pkg::ST_IDLE;
         end
         default: state_in = arp_pkg::ST_IDLE;
      endcase
   end

   assign state = state_ff;

endmodule

### rtl/arp_cache_resolver_top.sv
// Top level of the ARP cache resolver: controller, datapath and checks.
//
//  channel   direction  handshake          payload
//  req_ch    in         valid / ready      arp_pkg::req_type (one request)
//  rsp_ch    out        valid / ready      arp_pkg::rsp_type (one result)
//  csr_*     in         csr_wr_en only     csr_index selects own_ip / own_mac
//
// One request at a time: accepted in ST_IDLE, then ST_SCAN (one cache entry
// read per cycle from the memories), ST_APPLY, then ST_OUT_A and, for a
// second result, ST_OUT_B; a request with no result returns to ST_IDLE.
// Reset is synchronous; it clears all entries through the valid bits at once.
// A stalled rsp_ch holds the result register and blocks the next request.
module arp_cache_resolver_top #(
   parameter int ENTRIES     = arp_pkg::ENTRIES_DEF,
   parameter int HANDLE_BITS = arp_pkg::HANDLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   arp_chan_if.sink                  req_ch,
   arp_chan_if.source                rsp_ch,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [arp_pkg::CSR_W-1:0] csr_wr_data
);

   arp_pkg::ctrl_cmd_type ctrl_cmd;
   arp_pkg::dp_stat_type  dp_stat;
   arp_pkg::state_type    ctrl_state;
   arp_pkg::rsp_type      rsp_data;

   arp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .dp_stat   (dp_stat),
      .ctrl_cmd  (ctrl_cmd),
      .state     (ctrl_state)
   );

   arp_dpath #(
      .ENTRIES     (ENTRIES),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_ch.data),
      .ctrl_cmd    (ctrl_cmd),
      .dp_stat     (dp_stat),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   assign rsp_ch.data = rsp_data;

   // Never take a request while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request accepted while a result is pending");

   // An accepted request always starts the cache scan
   a_scan_follows: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (ctrl_state == arp_pkg::ST_SCAN))
      else $error("scan did not start after a request");

   // The second result of a request is always its final one
   a_second_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (ctrl_state == arp_pkg::ST_OUT_B)) |-> rsp_ch.data.last)
      else $error("second result not marked last");

   // Only a lookup answer can report a hit
   a_found_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.data.found) |->
      (rsp_ch.data.result_kind == arp_pkg::KIND_LOOKUP))
      else $error("found set on a result that is not a lookup answer");

endmodule
